@@ hdl/olte_pkg.sv @@
// ----------------------------------------------------------------------------
// olte_pkg
// Shared types and constants for the ordered list table engine.
// ----------------------------------------------------------------------------
package olte_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;

  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL_POS = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_VAL = 3'd2;
  localparam logic [OP_W-1:0] OP_READ    = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND    = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    status;
    logic signed [VAL_W-1:0] out_value;
    logic [POS_W-1:0]        out_position;
    logic [POS_W-1:0]        list_length;
    logic                    is_empty;
  } rsp_t;

endpackage

@@ hdl/ordered_list_table_engine.sv @@
// ----------------------------------------------------------------------------
// ordered_list_table_engine
// Fixed-capacity ordered list of signed words held in a single-port-write RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req (valid/ready) carries one request: op, one-based position, value.
//   rsp (valid/ready) returns one result per request: status, value,
//   position, list length and empty flag.
//   One request is worked at a time; req_ready is high only in idle.
//   Walks run one entry a cycle through the RAM's registered read port and
//   the address/compare unit. Insert at p shifts the entries from p onward
//   up, then writes the value (an append writes at once); delete at p
//   shifts the entries after p down; find and delete by value scan from
//   the first entry until a match, and a delete then shifts as above;
//   clear and errors go straight to the response.
//   A finished result sits in the rsp register; the next request is taken
//   meanwhile, and its result waits until rsp is taken.
//   Reset empties the list at once; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module ordered_list_table_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  olte_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output olte_pkg::rsp_t rsp
);
  import olte_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SHIFT_UP, S_DRAIN, S_INS_WRITE, S_LOOKUP, S_LOOKUP_CAP,
    S_SHIFT_DN, S_DEL_FIN, S_SEARCH, S_SEARCH_LAST, S_RESP
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        count;
  logic [OP_W-1:0]         op_r;
  logic [POS_W-1:0]        pos_r;
  logic signed [VAL_W-1:0] val_r;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        ptr;
  logic                    wr_pend;
  logic [IDX_W-1:0]        wr_addr;
  logic                    cmp_pend;
  logic [IDX_W-1:0]        cmp_idx;
  logic                    res_err;
  logic signed [VAL_W-1:0] res_val;
  logic [POS_W-1:0]        res_pos;

  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rdata;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata;
  logic [IDX_W-1:0]        mem_raddr;

  logic [POS_W-1:0]        count_w;
  logic [IDX_W-1:0]        cnt_m1;
  logic [IDX_W-1:0]        pos_idx;
  logic                    hit;

  assign req_ready = (state == S_IDLE);
  assign count_w   = POS_W'(count);
  assign cnt_m1    = IDX_W'(count - CNT_W'(1));
  assign pos_idx   = IDX_W'(req.position - POS_W'(1));
  assign hit       = cmp_pend && (rdata == val_r);

  always_comb begin
    mem_we    = wr_pend || (state == S_INS_WRITE);
    mem_waddr = (state == S_INS_WRITE) ? idx : wr_addr;
    mem_wdata = (state == S_INS_WRITE) ? val_r : rdata;
  end

  always_comb begin
    case (state)
      S_LOOKUP: mem_raddr = idx;
      default:  mem_raddr = ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      wr_pend   <= 1'b0;
      cmp_pend  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_RESP) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_r     <= req.op;
            pos_r    <= req.position;
            val_r    <= req.value;
            idx      <= pos_idx;
            wr_pend  <= 1'b0;
            cmp_pend <= 1'b0;
            res_val  <= '0;
            res_pos  <= '0;
            case (req.op)
              OP_INSERT: begin
                if (req.position == '0 || req.position > count_w + POS_W'(1) ||
                    count == CNT_W'(CAPACITY)) begin
                  res_err <= 1'b1;
                  state   <= S_RESP;
                end else if (req.position == count_w + POS_W'(1)) begin
                  res_err <= 1'b0;
                  state   <= S_INS_WRITE;
                end else begin
                  res_err <= 1'b0;
                  ptr     <= cnt_m1;
                  state   <= S_SHIFT_UP;
                end
              end
              OP_DEL_POS, OP_READ: begin
                if (req.position == '0 || req.position > count_w) begin
                  res_err <= 1'b1;
                  state   <= S_RESP;
                end else begin
                  res_err <= 1'b0;
                  state   <= S_LOOKUP;
                end
              end
              OP_DEL_VAL, OP_FIND: begin
                if (count == '0) begin
                  res_err <= 1'b1;
                  state   <= S_RESP;
                end else begin
                  res_err <= 1'b0;
                  ptr     <= '0;
                  state   <= S_SEARCH;
                end
              end
              OP_CLEAR: begin
                res_err <= 1'b0;
                count   <= '0;
                state   <= S_RESP;
              end
              default: begin
                res_err <= 1'b1;
                state   <= S_RESP;
              end
            endcase
          end
        end
        S_SHIFT_UP: begin
          wr_pend <= 1'b1;
          wr_addr <= ptr + IDX_W'(1);
          if (ptr == idx) begin
            state <= S_DRAIN;
          end else begin
            ptr <= ptr - IDX_W'(1);
          end
        end
        S_DRAIN: begin
          wr_pend <= 1'b0;
          state   <= (op_r == OP_INSERT) ? S_INS_WRITE : S_DEL_FIN;
        end
        S_INS_WRITE: begin
          count <= count + CNT_W'(1);
          state <= S_RESP;
        end
        S_LOOKUP: begin
          state <= S_LOOKUP_CAP;
        end
        S_LOOKUP_CAP: begin
          res_val <= rdata;
          res_pos <= pos_r;
          if (op_r == OP_READ) begin
            state <= S_RESP;
          end else if (idx == cnt_m1) begin
            state <= S_DEL_FIN;
          end else begin
            ptr   <= idx + IDX_W'(1);
            state <= S_SHIFT_DN;
          end
        end
        S_SHIFT_DN: begin
          wr_pend <= 1'b1;
          wr_addr <= ptr - IDX_W'(1);
          if (ptr == cnt_m1) begin
            state <= S_DRAIN;
          end else begin
            ptr <= ptr + IDX_W'(1);
          end
        end
        S_DEL_FIN: begin
          count <= count - CNT_W'(1);
          state <= S_RESP;
        end
        S_SEARCH, S_SEARCH_LAST: begin
          if (hit) begin
            cmp_pend <= 1'b0;
            res_pos  <= POS_W'(cmp_idx) + POS_W'(1);
            if (op_r == OP_FIND) begin
              state <= S_RESP;
            end else begin
              res_val <= val_r;
              idx     <= cmp_idx;
              if (cmp_idx == cnt_m1) begin
                state <= S_DEL_FIN;
              end else begin
                ptr   <= cmp_idx + IDX_W'(1);
                state <= S_SHIFT_DN;
              end
            end
          end else if (state == S_SEARCH_LAST) begin
            cmp_pend <= 1'b0;
            res_err  <= 1'b1;
            state    <= S_RESP;
          end else begin
            cmp_pend <= 1'b1;
            cmp_idx  <= ptr;
            if (ptr == cnt_m1) begin
              state <= S_SEARCH_LAST;
            end else begin
              ptr <= ptr + IDX_W'(1);
            end
          end
        end
        S_RESP: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid        <= 1'b1;
            rsp.status       <= res_err;
            rsp.out_value    <= res_val;
            rsp.out_position <= res_pos;
            rsp.list_length  <= count_w;
            rsp.is_empty     <= (count == '0);
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
